// File: design/signed_int_to_decimal_ascii_assert.svh
// Assertion macros for the checker file of the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define SITDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SITDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sitda_pkg.sv
// Package with the shared constants and helpers of the decimal text converter.
package sitda_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int Q_DEPTH        = 2;
  localparam int DAB_BITS       = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Decimal digits of the largest magnitude 2^(vb-1); 0.3 stands in for log10(2).
  function automatic int max_digits(input int vb);
    return ((vb - 1) * 3) / 10 + 1;
  endfunction

endpackage

// File: design/sitda_front.sv
// Front part: accepts words, splits sign and magnitude, and queues them.
module sitda_front
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         q_valid,
  input  logic                         q_pop,
  output logic                         q_neg,
  output logic        [VALUE_BITS-1:0] q_mag
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNTW = $clog2(Q_DEPTH + 1);

  logic [Q_DEPTH-1:0]                 ent_neg_r;
  logic [Q_DEPTH-1:0][VALUE_BITS-1:0] ent_mag_r;
  logic [PW-1:0]                      wr_ptr_r;
  logic [PW-1:0]                      rd_ptr_r;
  logic [CNTW-1:0]                    cnt_r;

  logic                  push;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;

  assign in_neg   = in_value[VALUE_BITS-1];
  assign in_mag   = in_neg ? VALUE_BITS'(-in_value) : VALUE_BITS'(in_value);
  assign in_stall = (cnt_r == CNTW'(Q_DEPTH));
  assign push     = in_valid && !in_stall;

  assign q_valid = (cnt_r != '0);
  assign q_neg   = ent_neg_r[rd_ptr_r];
  assign q_mag   = ent_mag_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        ent_neg_r[wr_ptr_r] <= in_neg;
        ent_mag_r[wr_ptr_r] <= in_mag;
        wr_ptr_r <= (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: design/sitda_back.sv
// Back part: converts a magnitude to decimal digits and sends the characters.
module sitda_back
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic                  q_neg,
  input  logic [VALUE_BITS-1:0] q_mag,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_character,
  output logic                  out_is_last
);

  localparam int MAXD       = max_digits(VALUE_BITS);
  localparam int CONV_STEPS = (VALUE_BITS + DAB_BITS - 1) / DAB_BITS;
  localparam int PAD_BITS   = CONV_STEPS * DAB_BITS;
  localparam int CW         = $clog2(CONV_STEPS);
  localparam int IW         = $clog2(MAXD);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

  state_t                state_r;
  logic [PAD_BITS-1:0]   mag_r;
  logic [MAXD*4-1:0]     bcd_r;
  logic                  neg_r;
  logic [CW-1:0]         step_r;
  logic [IW-1:0]         idx_r;
  logic                  out_valid_r;
  logic [7:0]            out_char_r;
  logic                  out_last_r;

  logic [PAD_BITS-1:0]   mag_dab;
  logic [MAXD*4-1:0]     bcd_dab;
  logic [IW-1:0]         top_idx;
  logic [3:0]            cur_digit;
  logic                  out_free;

  // Four shift-and-add-3 steps of the binary to BCD conversion per cycle.
  always_comb begin
    mag_dab = mag_r;
    bcd_dab = bcd_r;
    for (int s = 0; s < DAB_BITS; s++) begin
      for (int d = 0; d < MAXD; d++) begin
        if (bcd_dab[d*4 +: 4] >= 4'd5) begin
          bcd_dab[d*4 +: 4] = bcd_dab[d*4 +: 4] + 4'd3;
        end
      end
      bcd_dab = {bcd_dab[MAXD*4-2:0], mag_dab[PAD_BITS-1]};
      mag_dab = {mag_dab[PAD_BITS-2:0], 1'b0};
    end
  end

  always_comb begin
    top_idx = '0;
    for (int d = 0; d < MAXD; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) begin
        top_idx = IW'(d);
      end
    end
  end

  assign cur_digit = bcd_r[{idx_r, 2'b00} +: 4];
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_is_last   = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            mag_r   <= PAD_BITS'(q_mag);
            neg_r   <= q_neg;
            bcd_r   <= '0;
            step_r  <= CW'(CONV_STEPS - 1);
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_r <= mag_dab;
          bcd_r <= bcd_dab;
          if (step_r == '0) begin
            state_r <= ST_SIZE;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        ST_SIZE: begin
          idx_r   <= top_idx;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (neg_r) begin
              out_char_r <= CHAR_MINUS;
              out_last_r <= 1'b0;
              neg_r      <= 1'b0;
            end else begin
              out_char_r <= CHAR_ZERO + {4'd0, cur_digit};
              out_last_r <= (idx_r == '0);
              if (idx_r == '0) begin
                state_r <= ST_IDLE;
              end else begin
                idx_r <= idx_r - 1'b1;
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII text converter.
//
//   channel  direction  handshake             word
//   in_      input      in_valid / in_stall   in_value (signed, VALUE_BITS)
//   out_     output     out_valid / out_stall out_character (8), out_is_last (1)
//
// Each word is popped from the queue, converted from binary to BCD at four bits
// per cycle, sized by finding its top digit, and then sent one character at a
// time, the minus sign first.
// A two-word queue behind the input takes new words while the converter works.
// Reset is synchronous and active low; it empties the queue and the output.
// A stall on the output holds the current character and pauses the sending of characters.
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_character,
  output logic                         out_is_last
);

  logic                  q_valid;
  logic                  q_pop;
  logic                  q_neg;
  logic [VALUE_BITS-1:0] q_mag;

  sitda_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_neg    (q_neg),
    .q_mag    (q_mag)
  );

  sitda_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_neg         (q_neg),
    .q_mag         (q_mag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_is_last   (out_is_last)
  );

endmodule

// File: design/sitda_checker.sv
// Port checker of the decimal text converter and its bind to the top level.
`include "signed_int_to_decimal_ascii_assert.svh"

module sitda_checker
  import sitda_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_character,
  input logic       out_is_last
);

  `SITDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_character) && $stable(out_is_last), "Stalled output word changed.")
  `SITDA_ASSERT_NOW(a_char_set, out_valid, (out_character == CHAR_MINUS) || ((out_character >= CHAR_ZERO) && (out_character <= CHAR_NINE)), "Output character is not a digit or minus sign.")
  `SITDA_ASSERT_NOW(a_minus_not_last, out_valid && (out_character == CHAR_MINUS), !out_is_last, "Minus sign marked as last character.")
  `SITDA_ASSERT_NEXT(a_digit_after_minus, out_valid && !out_stall && (out_character == CHAR_MINUS), out_valid && (out_character != CHAR_ZERO) && (out_character != CHAR_MINUS), "Minus sign not followed at once by a nonzero digit.")

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps

module testbench;
  import sitda_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int DIRECTED_COUNT = 18;
  localparam int RANDOM_COUNT = 112;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
  } text_char_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [VB-1:0] in_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_character;
  logic                 out_is_last;

  text_char_t pending_chars[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int out_words = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit out_burst = 1'b0;
  bit in_burst = 1'b0;
  bit back_to_back = 1'b0;
  bit long_hold_req = 1'b0;
  bit hold_done = 1'b0;

  logic signed [VB-1:0] directed_values [DIRECTED_COUNT] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10,
    32'sd2147483647, 32'sh80000000, -32'sd2147483647,
    32'sd1000000000, 32'sd999999999, -32'sd1000000000,
    32'sd12345, -32'sd987654321, 32'sh55555555, 32'shAAAAAAAA,
    32'sd100, -32'sd99
  };

  // An empty string means the expected text comes from the predictor.
  string directed_text [DIRECTED_COUNT] = '{
    "0", "1", "-1", "9", "10", "-10",
    "2147483647", "-2147483648", "-2147483647",
    "1000000000", "999999999", "-1000000000",
    "", "", "", "",
    "", ""
  };

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VB)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_is_last  (out_is_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void push_decimal_text(input logic [VB-1:0] raw);
    logic [VB-1:0] magnitude;
    logic [3:0]    digits[$];
    magnitude = raw[VB-1] ? (~raw + 1'b1) : raw;
    do begin
      digits.push_back(4'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (raw[VB-1]) begin
      pending_chars.push_back(text_char_t'{CHAR_MINUS, 1'b0});
    end
    for (int k = digits.size() - 1; k >= 0; k--) begin
      pending_chars.push_back(text_char_t'{CHAR_ZERO + 8'(digits[k]), k == 0});
    end
  endfunction

  function automatic void push_literal_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      pending_chars.push_back(text_char_t'{8'(text[i]), i == text.len() - 1});
    end
  endfunction

  function automatic logic [VB-1:0] random_value();
    logic [63:0] pick;
    int unsigned scale;
    case ($urandom_range(0, 3))
      0: pick = {32'b0, $urandom()};
      1: pick = 64'($urandom_range(0, 999));
      2: begin
        scale = $urandom_range(0, 9);
        pick = 64'd1;
        repeat (scale) pick = pick * 10;
        pick = pick + $urandom_range(0, 2) - 1;
      end
      default: pick = 64'($urandom() >> $urandom_range(0, 31));
    endcase
    if ($urandom_range(0, 1) == 1) begin
      pick = -pick;
    end
    return pick[VB-1:0];
  endfunction

  task automatic send_value(input logic [VB-1:0] value, input string text);
    int gap;
    gap = (in_burst || back_to_back) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do begin
      @(posedge clk);
    end while (in_stall);
    if (text.len() > 0) begin
      push_literal_text(text);
    end else begin
      push_decimal_text(value);
    end
  endtask

  task automatic check_word(input logic [7:0] got_char, input logic got_last);
    text_char_t want;
    if (pending_chars.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("Unexpected word at cycle %0d: char %0d last %0b",
                 cycle_count, got_char, got_last);
      end
    end else begin
      want = pending_chars.pop_front();
      if (want.character !== got_char || want.is_last !== got_last) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Mismatch at cycle %0d: expected char %0d last %0b, got char %0d last %0b",
                   cycle_count, want.character, want.is_last, got_char, got_last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_word(out_character, out_is_last);
        out_words++;
        if (out_words % 16 == 0) begin
          out_burst = ($urandom_range(0, 3) == 0);
        end
        stall_left = out_burst ? 0 : $urandom_range(0, 6);
      end
      if (long_hold_req && !hold_done) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_value(directed_values[i], directed_text[i]);
    end
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_chars.size() != 0);

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i % 16 == 0) begin
        in_burst = ($urandom_range(0, 3) == 0);
      end
      // The receiver holds off while words keep coming, so the input queue fills.
      if (i == 40) begin
        long_hold_req = 1'b1;
        back_to_back = 1'b1;
      end
      if (i == 60) begin
        back_to_back = 1'b0;
      end
      if (i == 90) begin
        in_valid <= 1'b0;
        do begin
          @(posedge clk);
        end while (pending_chars.size() != 0);
      end
      send_value(random_value(), "");
    end
    in_valid <= 1'b0;

    do begin
      @(posedge clk);
    end while (pending_chars.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: signed_int_to_decimal_ascii.f
+incdir+design
design/sitda_pkg.sv
design/sitda_front.sv
design/sitda_back.sv
design/signed_int_to_decimal_ascii.sv
design/sitda_checker.sv
tb/testbench.sv
